// ----- rtl/core/bgie_pkg.sv -----
// Shared types, codes and result builders for the block-group index engine.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package bgie_pkg;

  // Field widths fixed by the item format
  localparam int unsigned NUM_W  = 40;  // block numbers and block count
  localparam int unsigned OFF_W  = 48;  // data store offsets
  localparam int unsigned CODE_W = 16;  // per-block code
  localparam int unsigned LEN_W  = 15;  // block size and read length
  localparam int unsigned GRP_W  = 6;   // group size, slots, remainders
  localparam int unsigned CNT_W  = 6;   // divider step counter, holds NUM_W
  localparam int unsigned CIDX_W = 1;   // configuration register index

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BLOCK_BYTES  = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_GROUP_BLOCKS = 1'd1;

  // Request types
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLOSE  = 2'd3
  } req_type_t;

  // Block kinds of an append; the two other codes are coded like a zero block
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DEP  = 2'd1;

  // Result kinds
  localparam logic [1:0] RES_ACCEPT = 2'd0;
  localparam logic [1:0] RES_WORD   = 2'd1;
  localparam logic [1:0] RES_ANSWER = 2'd2;

  // Lookup classes
  localparam logic [2:0] CLS_ZERO = 3'd0;
  localparam logic [2:0] CLS_COMP = 3'd1;
  localparam logic [2:0] CLS_RAW  = 3'd2;
  localparam logic [2:0] CLS_DEP  = 3'd3;
  localparam logic [2:0] CLS_NONE = 3'd4;

  // Special block codes
  localparam logic [CODE_W-1:0] CODE_ZERO_BLK = 16'h8000;
  localparam logic [CODE_W-1:0] CODE_RAW_BLK  = 16'h8001;

  typedef struct packed {
    req_type_t         req_type;
    logic [1:0]        block_kind;
    logic [15:0]       packed_len;
    logic [5:0]        dep_index;
    logic [OFF_W-1:0]  data_position;
    logic [5:0]        load_slot;
    logic [OFF_W-1:0]  load_value;
    logic [NUM_W-1:0]  block_number;
  } req_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [OFF_W-1:0]  word_value;
    logic [5:0]        word_slot;
    logic              raw_store;
    logic [2:0]        read_class;
    logic [OFF_W-1:0]  read_offset;
    logic [LEN_W-1:0]  read_length;
    logic [6:0]        dep_ref;
    logic              last;
  } rsp_t;

  // Plain acknowledge of an item
  function automatic rsp_t rsp_ack(input logic raw);
    rsp_t r;
    r           = '0;
    r.result_kind = RES_ACCEPT;
    r.raw_store = raw;
    r.last      = 1'b1;
    return r;
  endfunction

  // One word of an emitted index entry
  function automatic rsp_t rsp_word(input logic [OFF_W-1:0] value,
                                    input logic [5:0] slot,
                                    input logic raw, input logic fin);
    rsp_t r;
    r             = '0;
    r.result_kind = RES_WORD;
    r.word_value  = value;
    r.word_slot   = slot;
    r.raw_store   = raw;
    r.last        = fin;
    return r;
  endfunction

  // Lookup answer
  function automatic rsp_t rsp_answer(input logic [2:0] cls,
                                      input logic [OFF_W-1:0] off,
                                      input logic [LEN_W-1:0] len,
                                      input logic [6:0] dep);
    rsp_t r;
    r             = '0;
    r.result_kind = RES_ANSWER;
    r.read_class  = cls;
    r.read_offset = off;
    r.read_length = len;
    r.dep_ref     = dep;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bgie_if.sv -----
// Valid/ready channel interfaces for requests and results of the index engine.
// Depends on bgie_pkg for the payload types.
`default_nettype none

interface bgie_req_if import bgie_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bgie_rsp_if import bgie_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bgie_div.sv -----
// Restoring divider, one quotient bit per cycle: 40-bit dividend by 6-bit divisor.
// Depends on bgie_pkg for widths.
`default_nettype none

module bgie_div import bgie_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [GRP_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [GRP_W-1:0] remainder
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] quo;
  logic [GRP_W-1:0] rem;
  logic [GRP_W-1:0] dvs;
  logic [GRP_W:0]   shifted;
  logic [GRP_W+1:0] diff;
  logic             ge;

  // One trial subtraction per cycle
  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign ge      = ~diff[GRP_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Flag the cycle after the last quotient bit
      done <= ~start & busy & (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= {quo[NUM_W-2:0], ge};
        rem <= ge ? diff[GRP_W-1:0] : shifted[GRP_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// ----- rtl/core/block_group_index_engine_unit.sv -----
// Block-group index engine: builds and reads one index entry (a 48-bit base
// offset and one 16-bit code per block). Every request first runs a shared
// bit-serial divider, which hands over a quotient and a remainder to split the
// block number or block count into group and slot. Append, load and close
// then present their result, or an append or close flushes the entry; a lookup
// walks the codes up to its slot through the code RAM; an entry flush emits
// the base word and then one word per block of the group. Requests are taken
// one at a time; the result register lets the next request start while the
// last result of the previous one waits for its transfer.
`default_nettype none

module block_group_index_engine_unit import bgie_pkg::*; #(
  parameter int unsigned MAX_GROUP = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]  cfg_data,
  bgie_req_if.sink          req,
  bgie_rsp_if.source        rsp
);

  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam logic [GRP_W-1:0] MAX_G = GRP_W'(MAX_GROUP);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_EMIT, S_FL_BASE, S_FL_RD, S_FL_EMIT, S_WK_RD, S_WK_ACC
  } state_t;

  state_t state;

  // Configuration
  logic [LEN_W-1:0] block_bytes;
  logic [GRP_W-1:0] group_blocks;

  // Entry and bookkeeping
  logic [OFF_W-1:0]     entry_base;
  logic [MAX_GROUP-1:0] code_vld;
  logic [NUM_W-1:0]     block_count;
  logic [NUM_W-1:0]     loaded_group;
  logic                 loaded_valid;

  // Per-request working registers
  req_t             req_q;
  logic [GRP_W-1:0] g_q;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    slot_q;
  logic             raw_q;
  logic [OFF_W-1:0] acc;
  rsp_t             res_q;
  rsp_t             out_q;
  logic             out_valid;

  // Code RAM
  logic [CODE_W-1:0] codes [MAX_GROUP];
  logic [CODE_W-1:0] rd_data;
  logic              rd_vld;
  logic [CODE_W-1:0] rd_code;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [CODE_W-1:0] mem_wd;

  // Divider hookup
  logic             div_start;
  logic [NUM_W-1:0] div_dividend;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [GRP_W-1:0] div_rem;

  logic [GRP_W-1:0] g_eff;
  logic             out_free;
  logic             out_load;
  logic [20:0]      bytes63;
  logic [LEN_W-1:0] thr;
  logic             raw_c;
  logic [CODE_W-1:0] code_c;
  logic             slot_ok;
  logic [GRP_W-1:0] slot_m1;
  logic             switch_grp;
  logic [MAX_GROUP-1:0] code_vld_next;
  logic [OFF_W-1:0] entry_base_next;
  logic [GRP_W-1:0] idx_p1;
  logic [OFF_W-1:0] addend;
  logic [16:0]      dep_full;
  rsp_t             answer;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes  <= LEN_W'(4096);
      group_blocks <= GRP_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_BYTES:  block_bytes  <= cfg_data;
        CFG_GROUP_BLOCKS: group_blocks <= cfg_data[GRP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the group size to 1..MAX_GROUP
  always_comb begin
    if (group_blocks == '0)      g_eff = GRP_W'(1);
    else if (group_blocks > MAX_G) g_eff = MAX_G;
    else                         g_eff = group_blocks;
  end

  assign req.ready = (state == S_IDLE);
  assign out_free  = ~out_valid | rsp.ready;
  assign out_load  = out_free & ((state == S_EMIT) | (state == S_FL_BASE) |
                                 (state == S_FL_EMIT));
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  // Divide block count (append, close) or block number (load, lookup) by group
  assign div_start    = (state == S_IDLE) & req.valid;
  assign div_dividend = (req.data.req_type == REQ_APPEND || req.data.req_type == REQ_CLOSE)
                        ? block_count : req.data.block_number;

  bgie_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (g_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Append coding: raw when length reaches 63/64 of the block size
  assign bytes63 = {block_bytes, 6'b0} - {6'b0, block_bytes};
  assign thr     = bytes63[20:6];
  assign raw_c   = (req_q.block_kind == KIND_DATA) & (req_q.packed_len >= {1'b0, thr});

  always_comb begin
    if (req_q.block_kind == KIND_DATA)
      code_c = raw_c ? CODE_RAW_BLK : req_q.packed_len;
    else if (req_q.block_kind == KIND_DEP)
      code_c = ~{10'b0, req_q.dep_index};
    else
      code_c = CODE_ZERO_BLK;
  end

  assign slot_ok = (req_q.load_slot <= MAX_G);
  assign slot_m1 = req_q.load_slot - GRP_W'(1);

  // Entry after a load: a new group starts from an empty entry
  assign switch_grp = !loaded_valid || div_quo != loaded_group;
  always_comb begin
    code_vld_next   = switch_grp ? '0 : code_vld;
    entry_base_next = switch_grp ? '0 : entry_base;
    if (req_q.load_slot == '0) entry_base_next = req_q.load_value;
    else                       code_vld_next[slot_m1[AW-1:0]] = 1'b1;
  end

  // Code RAM write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = div_rem[AW-1:0];
    mem_wd = code_c;
    if (state == S_DIV && div_done) begin
      if (req_q.req_type == REQ_APPEND) begin
        mem_we = 1'b1;
      end else if (req_q.req_type == REQ_LOAD && slot_ok && req_q.load_slot != '0) begin
        mem_we = 1'b1;
        mem_wa = slot_m1[AW-1:0];
        mem_wd = req_q.load_value[CODE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) codes[mem_wa] <= mem_wd;
    rd_data <= codes[idx];
    rd_vld  <= code_vld[idx];
  end

  // A code never written since the last clear reads as zero
  assign rd_code = rd_vld ? rd_data : '0;

  // Walk: add compressed lengths and raw block sizes
  always_comb begin
    if (!rd_code[CODE_W-1])
      addend = {{(OFF_W-LEN_W){1'b0}}, rd_code[LEN_W-1:0]};
    else if (rd_code == CODE_RAW_BLK)
      addend = {{(OFF_W-LEN_W){1'b0}}, block_bytes};
    else
      addend = '0;
  end

  // Classify the code at the looked-up slot
  assign dep_full = 17'h10000 - {1'b0, rd_code};
  always_comb begin
    if (rd_code == '0 || rd_code == CODE_ZERO_BLK)
      answer = rsp_answer(CLS_ZERO, '0, '0, '0);
    else if (rd_code == CODE_RAW_BLK)
      answer = rsp_answer(CLS_RAW, acc, block_bytes, '0);
    else if (!rd_code[CODE_W-1])
      answer = rsp_answer(CLS_COMP, acc, rd_code[LEN_W-1:0], '0);
    else if (dep_full <= 17'd64)
      answer = rsp_answer(CLS_DEP, '0, '0, dep_full[6:0]);
    else
      answer = rsp_answer(CLS_NONE, '0, '0, '0);
  end

  assign idx_p1 = GRP_W'(idx) + GRP_W'(1);

  // Sequencer, entry state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      entry_base   <= '0;
      code_vld     <= '0;
      block_count  <= '0;
      loaded_group <= '0;
      loaded_valid <= 1'b0;
    end else begin
      // Hold the result until its transfer, refill when a new one is loaded
      if (out_load)       out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_q <= req.data;
            g_q   <= g_eff;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            unique case (req_q.req_type)
              REQ_APPEND: begin
                if (div_rem == '0) entry_base <= req_q.data_position;
                code_vld[mem_wa] <= 1'b1;
                block_count      <= block_count + 1'b1;
                loaded_valid     <= 1'b0;
                raw_q            <= raw_c;
                if (div_rem == g_q - 1'b1) begin
                  state <= S_FL_BASE;
                end else begin
                  res_q <= rsp_ack(raw_c);
                  state <= S_EMIT;
                end
              end

              REQ_CLOSE: begin
                block_count  <= '0;
                loaded_valid <= 1'b0;
                raw_q        <= 1'b0;
                if (div_rem != '0) begin
                  state <= S_FL_BASE;
                end else begin
                  res_q <= rsp_ack(1'b0);
                  state <= S_EMIT;
                end
              end

              REQ_LOAD: begin
                if (slot_ok) begin
                  // Switching groups drops the old entry first
                  if (switch_grp) begin
                    loaded_group <= div_quo;
                    loaded_valid <= 1'b1;
                  end
                  code_vld   <= code_vld_next;
                  entry_base <= entry_base_next;
                end
                res_q <= rsp_ack(1'b0);
                state <= S_EMIT;
              end

              REQ_LOOKUP: begin
                if (!loaded_valid || div_quo != loaded_group) begin
                  res_q <= rsp_answer(CLS_NONE, '0, '0, '0);
                  state <= S_EMIT;
                end else begin
                  acc    <= entry_base;
                  idx    <= '0;
                  slot_q <= div_rem[AW-1:0];
                  state  <= S_WK_RD;
                end
              end
            endcase
          end
        end

        S_WK_RD: state <= S_WK_ACC;

        S_WK_ACC: begin
          if (idx == slot_q) begin
            res_q <= answer;
            state <= S_EMIT;
          end else begin
            acc   <= acc + addend;
            idx   <= idx + 1'b1;
            state <= S_WK_RD;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_q <= res_q;
            state <= S_IDLE;
          end
        end

        S_FL_BASE: begin
          if (out_free) begin
            out_q <= rsp_word(entry_base, '0, raw_q, 1'b0);
            idx   <= '0;
            state <= S_FL_RD;
          end
        end

        S_FL_RD: state <= S_FL_EMIT;

        S_FL_EMIT: begin
          if (out_free) begin
            out_q <= rsp_word({{(OFF_W-CODE_W){1'b0}}, rd_code}, idx_p1, raw_q,
                              idx_p1 == g_q);
            if (idx_p1 == g_q) begin
              // Entry emitted: clear it
              code_vld   <= '0;
              entry_base <= '0;
              state      <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_FL_RD;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
